FILE: sv/fir_pkg.sv
package fir_pkg;

  // Sample and coefficient width (Q1.15 coefficients, 16-bit signed samples)
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned COEF_IDX_W = 6;
  localparam int unsigned TAPS_W     = 7;

  localparam int unsigned MAX_TAPS_DEF = 64;

  localparam logic [TAPS_W-1:0] TAPS_RST = 7'd23;

  // Transaction function codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } fir_state_e;

  // Control broadcast to every cell of the tap row
  typedef struct packed {
    logic shift;   // take the sample of the left neighbour
    logic rotate;  // take sample and coefficient of the right neighbour
  } fir_cell_ctrl_t;

  // Control of the multiply-accumulate unit
  typedef struct packed {
    logic clr;     // zero the accumulator
    logic mul;     // multiply the head cell, product counts if tap_en
    logic tap_en;  // current tap lies inside the taps in use
  } fir_mac_ctrl_t;

endpackage

FILE: sv/fir_in_if.sv
interface fir_in_if;
  import fir_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [DATA_W-1:0]         sample;
  logic        [COEF_IDX_W-1:0]     coef_index;
  logic signed [DATA_W-1:0]         coef_value;

  modport source (output valid, output func, output sample, output coef_index,
                  output coef_value, input ready);
  modport sink   (input valid, input func, input sample, input coef_index,
                  input coef_value, output ready);
endinterface

FILE: sv/fir_out_if.sv
interface fir_out_if;
  import fir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

FILE: sv/fir_lowpass_filter_unit.sv
// Direct-form FIR filter built as a row of MAX_TAPS tap cells, each holding one
// delayed sample and one Q1.15 coefficient, both zero after reset. A filter
// transaction (func 0) shifts the new sample into the row, then the row rotates
// once round its full length while a single multiply-accumulate unit at the head
// cell takes one tap a cycle; taps at or beyond taps_in_use (saturated to
// MAX_TAPS) are skipped, and the sum is rounded, shifted right by 15 and
// saturated to 16 bits. The shift happens at the accepting edge; the row then
// rotates through all MAX_TAPS cells, a drain step moves the last product into
// the accumulator, and the sum enters the output register as the unit returns
// to idle and the input reopens. The input stays closed for the whole pass, so
// a new sample is taken only once the last is through. A result still waiting
// in the output register holds the unit until the sink takes it. A coefficient
// write (func 1) produces no output and leaves the unit idle; indices at or
// beyond MAX_TAPS are dropped. The output register lets the next item be
// accepted while a result waits for the sink. Write taps_in_use only while idle.
module fir_lowpass_filter_unit
  import fir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TAPS_W-1:0] cfg_wdata_i,
  fir_in_if.sink            in_i,
  fir_out_if.source         out_o
);

  localparam int unsigned IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned ACC_W = PROD_W + IDX_W;
  localparam int unsigned CMP_W = (IDX_W + 1 > TAPS_W) ? IDX_W + 1 : TAPS_W;
  localparam int unsigned WIX_W = (IDX_W > COEF_IDX_W) ? IDX_W : COEF_IDX_W;
  localparam int unsigned SHR_W = ACC_W - FRAC_W;

  // Configuration register
  logic [TAPS_W-1:0] taps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RST;
    end else if (cfg_we_i) begin
      taps_q <= cfg_wdata_i;
    end
  end

  // Sequencer
  fir_state_e       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             in_acc;
  logic             smp_acc;
  logic             coef_acc;
  logic             tap_en;
  fir_cell_ctrl_t   cell_ctrl;
  fir_mac_ctrl_t    mac_ctrl;

  logic                     out_vld_q, out_vld_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic signed [DATA_W-1:0] result;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign smp_acc    = in_acc & (in_i.func == FUNC_FILTER);
  assign coef_acc   = in_acc & (in_i.func == FUNC_COEF);

  // The head cell holds tap cnt_q during the rotation pass
  assign tap_en = CMP_W'(cnt_q) < CMP_W'(taps_q);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clr     = 1'b0;
    mac_ctrl.mul     = 1'b0;
    mac_ctrl.tap_en  = tap_en;
    out_vld_d        = out_vld_q & ~out_o.ready;
    out_data_d       = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          cell_ctrl.shift = 1'b1;
          mac_ctrl.clr    = 1'b1;
          cnt_d           = '0;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul     = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(MAX_TAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        // hold the result until the output register is free
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_data_d = result;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = out_data_q;

  // Tap row: cell 0 takes the new sample, and on rotation cell 0 wraps to the last cell
  logic signed [DATA_W-1:0] cell_smp  [MAX_TAPS];
  logic signed [DATA_W-1:0] cell_coef [MAX_TAPS];

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == MAX_TAPS - 1) ? 0 : i + 1;
    logic                     we;
    logic signed [DATA_W-1:0] left_smp;

    assign we       = coef_acc & (WIX_W'(in_i.coef_index) == WIX_W'(i));
    assign left_smp = (i == 0) ? in_i.sample : cell_smp[L];

    fir_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl),
      .left_sample_i  (left_smp),
      .right_sample_i (cell_smp[R]),
      .right_coef_i   (cell_coef[R]),
      .coef_we_i      (we),
      .coef_wdata_i   (in_i.coef_value),
      .sample_o       (cell_smp[i]),
      .coef_o         (cell_coef[i])
    );
  end

  logic signed [ACC_W-1:0] acc;

  fir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (cell_coef[0]),
    .sample_i (cell_smp[0]),
    .acc_o    (acc)
  );

  // Round to nearest, drop the fraction, saturate to 16 bits
  logic signed [ACC_W-1:0] rnd;
  logic signed [SHR_W-1:0] shr;

  always_comb begin
    rnd = acc + ACC_W'(16384);
    shr = $signed(rnd[ACC_W-1:FRAC_W]);
    if (shr > SHR_W'(32767)) begin
      result = 16'sh7FFF;
    end else if (shr < -SHR_W'(32768)) begin
      result = 16'sh8000;
    end else begin
      result = shr[DATA_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_smp_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("sample transaction did not start the rotation pass");

  a_coef_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_acc |=> (state_q == ST_IDLE))
    else $error("coefficient write left the idle state");

  a_out_from_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && (out_vld_q != $past(out_vld_q)) && out_vld_q
      |-> ($past(state_q) == ST_HOLD))
    else $error("output became valid without a finished sum");

  a_acc_stable_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) && ($past(state_q) == ST_HOLD) |-> $stable(acc))
    else $error("accumulator moved while the result was held");
`endif

endmodule

FILE: sv/fir_cell.sv
module fir_cell
  import fir_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fir_cell_ctrl_t           ctrl_i,
  input  logic signed [DATA_W-1:0] left_sample_i,
  input  logic signed [DATA_W-1:0] right_sample_i,
  input  logic signed [DATA_W-1:0] right_coef_i,
  input  logic                     coef_we_i,
  input  logic signed [DATA_W-1:0] coef_wdata_i,
  output logic signed [DATA_W-1:0] sample_o,
  output logic signed [DATA_W-1:0] coef_o
);

  logic signed [DATA_W-1:0] sample_q, sample_d;
  logic signed [DATA_W-1:0] coef_q, coef_d;

  always_comb begin
    sample_d = sample_q;
    coef_d   = coef_q;
    priority if (ctrl_i.rotate) begin
      sample_d = right_sample_i;
      coef_d   = right_coef_i;
    end else if (ctrl_i.shift) begin
      sample_d = left_sample_i;
    end else if (coef_we_i) begin
      coef_d = coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coef_q   <= '0;
    end else begin
      sample_q <= sample_d;
      coef_q   <= coef_d;
    end
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule

FILE: sv/fir_mac.sv
module fir_mac
  import fir_pkg::*;
#(
  parameter int unsigned ACC_W = PROD_W + 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fir_mac_ctrl_t            ctrl_i,
  input  logic signed [DATA_W-1:0] coef_i,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_vld_q, prod_vld_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  always_comb begin
    prod_d     = coef_i * sample_i;
    prod_vld_d = ctrl_i.mul & ctrl_i.tap_en & ~ctrl_i.clr;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= prod_vld_d;
      acc_q      <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
